// ===== hdl/utf8d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Widths, byte classification limits, masks and the result record shared by
// the decoder modules and its channel interfaces.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W         = 8;
  localparam int CP_W           = 21;
  localparam int TOTAL_W        = 16;
  localparam int CONT_W         = 6;
  localparam int COUNT_BITS_DEF = 16;

  // Lead byte classification limits.
  localparam logic [BYTE_W-1:0] ASCII_LIM = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;

  // Payload masks for lead bytes of two, three and four byte sequences.
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic               end_of_string;
    logic [TOTAL_W-1:0] char_total;
    logic               truncated;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/utf8d_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder byte channel
// Valid/ready channel carrying one byte of the string per request.
// ----------------------------------------------------------------------------
interface utf8d_in_if import utf8d_pkg::*;;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);

endinterface
`default_nettype wire

// ===== hdl/utf8d_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder result channel
// Valid/ready channel carrying one decoded character or end marker.
// ----------------------------------------------------------------------------
interface utf8d_out_if import utf8d_pkg::*;;

  logic               valid;
  logic               ready;
  logic [CP_W-1:0]    code_point;
  logic               end_of_string;
  logic [TOTAL_W-1:0] char_total;
  logic               truncated;

  modport source (output valid, output code_point, output end_of_string,
                  output char_total, output truncated, input ready);
  modport sink   (input valid, input code_point, input end_of_string,
                  input char_total, input truncated, output ready);

endinterface
`default_nettype wire

// ===== hdl/utf8d_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Holds the pending byte count, the partial character and the character
// count, and works out the result that each accepted byte produces.
// ----------------------------------------------------------------------------
module utf8d_core import utf8d_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] byte_in,
  output logic              res_valid,
  output result_t           res
);

  localparam int EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  logic [1:0]            pend_r, pend_nxt;
  logic [CP_W-1:0]       part_r, part_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [COUNT_BITS-1:0] cnt_inc;
  logic [EXT_W-1:0]      cnt_ext;
  logic [CP_W-1:0]       part_shift;

  // The count stops at its maximum rather than wrapping.
  assign cnt_inc    = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  assign cnt_ext    = EXT_W'(cnt_r);
  assign part_shift = {part_r[CP_W-CONT_W-1:0], byte_in[CONT_W-1:0]};

  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res       = '0;
    if (byte_in == '0) begin
      res_valid         = 1'b1;
      res.end_of_string = 1'b1;
      res.char_total    = cnt_ext[TOTAL_W-1:0];
      res.truncated     = (pend_r != 2'd0);
      pend_nxt          = 2'd0;
      part_nxt          = '0;
      cnt_nxt           = '0;
    end else if (pend_r == 2'd0) begin
      if (byte_in < ASCII_LIM) begin
        res_valid      = 1'b1;
        res.code_point = CP_W'(byte_in);
        cnt_nxt        = cnt_inc;
      end else if (byte_in < LEAD3_MIN) begin
        part_nxt = CP_W'(byte_in & LEAD2_MASK);
        pend_nxt = 2'd1;
      end else if (byte_in < LEAD4_MIN) begin
        part_nxt = CP_W'(byte_in & LEAD3_MASK);
        pend_nxt = 2'd2;
      end else begin
        part_nxt = CP_W'(byte_in & LEAD4_MASK);
        pend_nxt = 2'd3;
      end
    end else begin
      // Any nonzero byte inside a sequence counts as a continuation.
      pend_nxt = pend_r - 2'd1;
      if (pend_r == 2'd1) begin
        res_valid      = 1'b1;
        res.code_point = part_shift;
        part_nxt       = '0;
        cnt_nxt        = cnt_inc;
      end else begin
        part_nxt = part_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      part_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8d_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder output stage
// Result register that drives the result channel and tells the input side
// whether a new byte can be taken in this cycle.
// ----------------------------------------------------------------------------
module utf8d_out_stage import utf8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        space,
  utf8d_out_if.source out_ch
);

  logic    valid_r;
  result_t res_r;

  // The register can take a new result when empty or being drained now.
  assign space = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.code_point    = res_r.code_point;
  assign out_ch.end_of_string = res_r.end_of_string;
  assign out_ch.char_total    = res_r.char_total;
  assign out_ch.truncated     = res_r.truncated;

endmodule
`default_nettype wire

// ===== hdl/utf8_to_code_point_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to code point decoder
// A result is presented in the cycle after the byte request that completes
// it. Throughput: one byte per cycle, set by the state update; while a
// result waits and is not being taken, bytes are held off.
// Reset clears the pending count, partial character and character count.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder import utf8d_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_in_if.sink    in_ch,
  utf8d_out_if.source out_ch
);

  logic    accept;
  logic    space;
  logic    res_valid;
  result_t res;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  utf8d_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .byte_in   (in_ch.byte_in),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8d_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept && res_valid),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // A stalled result must block further bytes.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("byte accepted while result stalled");

  // A terminating zero byte always yields an end marker next cycle.
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.byte_in == '0)
      |=> out_ch.valid && out_ch.end_of_string)
    else $error("zero byte did not produce an end marker");

  // Character results carry no count or truncation flag.
  a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.end_of_string
      |-> (out_ch.char_total == '0) && !out_ch.truncated)
    else $error("character result carries end marker fields");

  // The end marker carries a zero code point.
  a_end_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_string |-> (out_ch.code_point == '0))
    else $error("end marker with nonzero code point");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_utf8_to_code_point_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Feeds NUL-terminated byte strings into the decoder over its valid/ready
// byte channel. A scoreboard decodes every accepted byte itself and compares
// each result against the oldest outstanding character or end marker. It uses
// directed strings, a long run of random strings with malformed and cut-short
// sequences mixed in, and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_utf8_to_code_point_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int          COUNT_BITS   = COUNT_BITS_DEF;
  localparam int          RANDOM_BYTES = 800;
  localparam longint      LIMIT_CYCLES = 400_000;
  localparam logic [7:0]  NUL          = 8'h00;

  // Character extremes, every lead class, stray continuations taken as leads,
  // non-continuation bytes inside a sequence, an empty string and a string
  // cut short in the middle of a four-byte sequence.
  localparam logic [7:0] DIRECTED [27] = '{
    8'h41, 8'h7F,
    8'hC3, 8'hA9,
    8'h80, 8'h80,
    8'hDF, 8'hBF,
    8'hE2, 8'h82, 8'hAC,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hFF, 8'hBF, 8'hBF, 8'hBF,
    8'hE0, 8'h41, 8'h42,
    NUL,
    NUL,
    8'hF0, 8'h90, NUL
  };

  class code_point_scoreboard;
    bit [1:0]          bytes_left;
    bit [CP_W-1:0]     partial_cp;
    longint unsigned   chars_seen;
    longint unsigned   count_limit;
    result_t           expected_chars[$];
    int unsigned       mismatches;
    int unsigned       strings_done;
    int unsigned       cut_short;
    int unsigned       results_checked;
    int unsigned       max_total;

    function new(int count_bits);
      count_limit = (count_bits >= 64) ? '1 : ((64'd1 << count_bits) - 1);
    endfunction

    function void count_char();
      if (chars_seen < count_limit) chars_seen++;
    endfunction

    // Works out what the decoder owes for one accepted byte request.
    function void decode_byte(logic [BYTE_W-1:0] b);
      result_t r;
      r = '0;
      if (b == NUL) begin
        r.end_of_string = 1'b1;
        r.char_total    = chars_seen[TOTAL_W-1:0];
        r.truncated     = (bytes_left != 0);
        expected_chars.push_back(r);
        strings_done++;
        if (r.truncated) cut_short++;
        if (r.char_total > max_total) max_total = r.char_total;
        bytes_left = 0;
        partial_cp = '0;
        chars_seen = 0;
      end else if (bytes_left == 0) begin
        if (b < ASCII_LIM) begin
          count_char();
          r.code_point = CP_W'(b);
          expected_chars.push_back(r);
        end else if (b < LEAD3_MIN) begin
          partial_cp = CP_W'(b & LEAD2_MASK);
          bytes_left = 2'd1;
        end else if (b < LEAD4_MIN) begin
          partial_cp = CP_W'(b & LEAD3_MASK);
          bytes_left = 2'd2;
        end else begin
          partial_cp = CP_W'(b & LEAD4_MASK);
          bytes_left = 2'd3;
        end
      end else begin
        // Any nonzero byte inside a sequence counts as a continuation.
        partial_cp = {partial_cp[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
        bytes_left--;
        if (bytes_left == 0) begin
          count_char();
          r.code_point = partial_cp;
          expected_chars.push_back(r);
          partial_cp = '0;
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result cp=%h eos=%b total=%0d trunc=%b",
                   $realtime, got.code_point, got.end_of_string, got.char_total,
                   got.truncated);
        return;
      end
      want = expected_chars.pop_front();
      results_checked++;
      if (got.code_point !== want.code_point || got.end_of_string !== want.end_of_string ||
          got.char_total !== want.char_total || got.truncated !== want.truncated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected cp=%h eos=%b total=%0d trunc=%b, %s",
                   $realtime, want.code_point, want.end_of_string, want.char_total,
                   want.truncated,
                   $sformatf("got cp=%h eos=%b total=%0d trunc=%b", got.code_point,
                             got.end_of_string, got.char_total, got.truncated));
      end
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  utf8d_in_if  in_ch();
  utf8d_out_if out_ch();

  utf8_to_code_point_decoder #(
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  code_point_scoreboard sb;

  int unsigned bytes_sent   = 0;
  int unsigned burst_left   = 0;
  bit          tx_open      = 1'b0;
  bit          long_hold_due = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_mode      = 0;

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.byte_in  = '0;
    out_ch.ready   = 1'b0;
  end

  always #6 clk = ~clk;

  // Result side: random stall pattern, with one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (long_hold_due) begin
      long_hold_due = 1'b0;
      hold_left     = 59;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       = $urandom_range(0, 3);
        rx_phase_left = $urandom_range(20, 80);
      end
      rx_phase_left--;
      out_ch.ready <= ($urandom_range(0, 3) >= rx_mode);
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.decode_byte(in_ch.byte_in);
      if (out_ch.valid && out_ch.ready) begin
        got.code_point    = out_ch.code_point;
        got.end_of_string = out_ch.end_of_string;
        got.char_total    = out_ch.char_total;
        got.truncated     = out_ch.truncated;
        sb.check_result(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_open ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Holds the byte channel idle until every owed result has been taken.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic send_continuations(input int n);
    for (int i = 0; i < n; i++) send_byte(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // Mostly well-formed strings with random content; some noise bytes, stray
  // continuations and strings that stop in the middle of a sequence.
  task automatic send_random_string();
    int n_chars;
    int kind;
    n_chars = $urandom_range(0, 14);
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(1, 255)));
      end else begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin
            send_byte(8'($urandom_range(1, 8'h7F)));
          end
          1: begin
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(8'h80, 8'hBF)));
            else send_byte(8'($urandom_range(8'hC0, 8'hDF)));
            send_continuations(1);
          end
          2: begin
            send_byte(8'($urandom_range(8'hE0, 8'hEF)));
            send_continuations(2);
          end
          default: begin
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(8'hF8, 8'hFF)));
            else send_byte(8'($urandom_range(8'hF0, 8'hF7)));
            send_continuations(3);
          end
        endcase
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      send_byte(8'($urandom_range(8'hC0, 8'hFF)));
      if ($urandom_range(0, 1) == 1) send_continuations(1);
    end
    send_byte(NUL);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    bit          hold_done;
    bit          drain_done;
    sb = new(COUNT_BITS);
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    wait_all_results();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (!hold_done && bytes_sent - random_start >= 300) begin
        // Result side holds off while bytes keep coming, so the block must
        // fill up and push back on the byte channel.
        hold_done     = 1'b1;
        long_hold_due = 1'b1;
        tx_open       = 1'b1;
        repeat (3) send_random_string();
        tx_open       = 1'b0;
      end
      if (!drain_done && bytes_sent - random_start >= 550) begin
        drain_done = 1'b1;
        wait_all_results();
      end
      send_random_string();
    end

    wait_all_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d bytes forming %0d strings (%0d cut short); %0d results checked.",
             bytes_sent, sb.strings_done, sb.cut_short, sb.results_checked);
    $display("Largest character total seen %0d; %0d mismatches.",
             sb.max_total, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 12);
    $display("Timeout after %0d cycles.", LIMIT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

endmodule
